/* hw/rtl/gtgvc_pkg.sv */
// shared types, constants and helper functions of the go-to-goal velocity command unit
package gtgvc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CRUISE  = 3'd0,
    REG_TOL     = 3'd1,
    REG_MAX_LIN = 3'd2,
    REG_MIN_LIN = 3'd3,
    REG_MAX_ANG = 3'd4,
    REG_MIN_ANG = 3'd5
  } reg_idx_t;

  localparam int REG_W      = 15;
  localparam int SQRT_STEPS = 31;  // root bits of a 62-bit radicand
  localparam int DIV_STEPS  = 15;  // quotient never exceeds the cruise speed
  localparam int ATAN_STEPS = 24;

  // angles in Q.30 radians
  localparam logic signed [34:0] PI_W     = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_W = 35'sd6746518852;
  localparam logic signed [33:0] PI_Z     = 34'sd3373259426;
  localparam logic signed [33:0] HALF_Z   = 34'sd1686629713;

  // inverse cordic gain in Q.16 and rounding constant for the final >>> 30
  localparam logic signed [49:0] INV_GAIN = 50'sd39796;
  localparam logic signed [49:0] RND_HALF = 50'sd536870912;

  localparam logic [29:0] ATAN_Q30 [0:ATAN_STEPS-1] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127
  };

  // item data ahead of the square root
  typedef struct packed {
    logic [29:0]        sx;
    logic [29:0]        sy;
    logic [29:0]        st;
    logic               neg_x;
    logic               neg_y;
    logic               neg_t;
    logic               goal;
    logic signed [32:0] angle;
  } pre_t;

  // one square root cell's view of an item
  typedef struct packed {
    logic [61:0] rem;
    logic [30:0] root;
    pre_t        side;
  } sq_t;

  // item data carried past the square root
  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic               neg_t;
    logic               goal;
    logic               zero;
    logic signed [32:0] angle;
  } post_t;

  // one divider cell's view of an item, three lanes sharing a divisor
  typedef struct packed {
    logic [30:0] n;
    logic [45:0] rem_x;
    logic [45:0] rem_y;
    logic [45:0] rem_t;
    logic [14:0] q_x;
    logic [14:0] q_y;
    logic [14:0] q_t;
    post_t       side;
  } dv_t;

  // one cordic cell's view of an item
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [33:0] z;
    logic signed [15:0] vt;
    logic               goal;
    logic               zero;
  } cd_t;

  // result item
  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_turn;
    logic               goal_reached;
  } res_t;

  // one step of wrapping an angle into [-pi, pi]
  function automatic logic signed [34:0] wrap_step(logic signed [34:0] a);
    if (a > PI_W) return a - TWO_PI_W;
    else if (a < -PI_W) return a + TWO_PI_W;
    return a;
  endfunction

  // clamp to maximum magnitude, then raise small nonzero values to the minimum
  function automatic logic signed [19:0] bound(logic signed [19:0] v, logic [14:0] mx,
                                                logic [14:0] mn);
    logic signed [19:0] smx;
    logic signed [19:0] smn;
    logic signed [19:0] r;
    smx = 20'(mx);
    smn = 20'(mn);
    r = v;
    if (r > smx) r = smx;
    else if (r < -smx) r = -smx;
    if (r > 0 && r < smn) r = smn;
    else if (r < 0 && r > -smn) r = -smn;
    return r;
  endfunction

endpackage

/* hw/rtl/go_to_goal_velocity_command_unit.sv */
// top level of the go-to-goal velocity command unit
//
// Input channel: one transfer carries the robot pose and the target pose
// (in_valid / in_stall). Output channel: one transfer carries vel_x, vel_y,
// vel_turn and goal_reached (out_valid / out_stall). Every input transfer
// yields exactly one output transfer, in order.
// The path runs through four front stages for difference, scaling, squares
// and sum, 31 square root cells, one numerator stage, 15 divider cells, one
// fold stage, the cordic cells (iterations above 24 count as 24), one gain
// multiply, one round/clamp stage and the output register. Throughput is one
// item per cycle while the pipeline is not held by a receiver stall.
// A skid register sits beside the output register. When the receiver
// stalls, one more result lands in the skid register and then the whole
// pipeline holds and in_stall rises until the skid register drains.
// Reset (synchronous, rst high) empties all stages and loads the register
// reset values. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once and are meant for idle periods only.
module go_to_goal_velocity_command_unit #(
  parameter int POS_WIDTH         = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [gtgvc_pkg::REG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_WIDTH-1:0] robot_x,
  input  logic signed [POS_WIDTH-1:0] robot_y,
  input  logic signed [15:0]          robot_heading,
  input  logic signed [POS_WIDTH-1:0] target_x,
  input  logic signed [POS_WIDTH-1:0] target_y,
  input  logic signed [15:0]          target_heading,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          vel_x,
  output logic signed [15:0]          vel_y,
  output logic signed [15:0]          vel_turn,
  output logic                        goal_reached
);
  import gtgvc_pkg::*;

  localparam int DW = POS_WIDTH + 1;
  localparam int CW = (POS_WIDTH > REG_W) ? POS_WIDTH : REG_W;
  localparam int SW = $clog2(POS_WIDTH);
  localparam int NC = (CORDIC_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_ITERATIONS;

  // configuration registers
  logic [REG_W-1:0] cruise, tol, max_lin, min_lin, max_ang, min_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      cruise  <= 15'd12800;
      tol     <= 15'd150;
      max_lin <= 15'd7680;
      min_lin <= 15'd0;
      max_ang <= 15'd3217;
      min_ang <= 15'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRUISE:  cruise  <= cfg_data;
        REG_TOL:     tol     <= cfg_data;
        REG_MAX_LIN: max_lin <= cfg_data;
        REG_MIN_LIN: min_lin <= cfg_data;
        REG_MAX_ANG: max_ang <= cfg_data;
        REG_MIN_ANG: min_ang <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: the pipeline moves unless the skid register is full
  logic en;
  logic s_v;
  assign en       = !s_v;
  assign in_stall = s_v;

  // stage a: differences, magnitudes, goal test, heading angle
  logic signed [DW-1:0]    dx, dy;
  logic signed [16:0]      dt;
  logic signed [34:0]      ang0;
  logic                    a_v, a_nx, a_ny, a_nt, a_goal;
  logic [POS_WIDTH-1:0]    a_ax, a_ay;
  logic [15:0]             a_at;
  logic signed [32:0]      a_ang;
  logic [POS_WIDTH-1:0]    ax_c, ay_c;

  assign dx   = DW'(target_x) - DW'(robot_x);
  assign dy   = DW'(target_y) - DW'(robot_y);
  assign dt   = 17'(target_heading) - 17'(robot_heading);
  assign ax_c = POS_WIDTH'(dx[DW-1] ? -dx : dx);
  assign ay_c = POS_WIDTH'(dy[DW-1] ? -dy : dy);
  assign ang0 = -(35'(robot_heading) <<< 18);

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_valid;
  end

  // one wrap step brings any Q4.12 heading into [-pi, pi]
  always_ff @(posedge clk) begin
    if (en) begin
      a_ax   <= ax_c;
      a_ay   <= ay_c;
      a_at   <= 16'(dt[16] ? -dt : dt);
      a_nx   <= dx[DW-1];
      a_ny   <= dy[DW-1];
      a_nt   <= dt[16];
      a_goal <= (CW'(ax_c) <= CW'(tol)) && (CW'(ay_c) <= CW'(tol));
      a_ang  <= 33'(wrap_step(ang0));
    end
  end

  // stage b: common right shift so every magnitude is below 2^30
  logic [POS_WIDTH-1:0] mm;
  logic [SW-1:0]        sh;
  logic                 b_v;
  pre_t                 b_side;

  always_comb begin
    mm = (a_ax > a_ay) ? a_ax : a_ay;
    sh = '0;
    for (int b = 0; b < POS_WIDTH; b++) begin
      if (mm[b] && b >= 18) sh = SW'(b - 17);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side.sx    <= 30'({a_ax, 12'd0} >> sh);
      b_side.sy    <= 30'({a_ay, 12'd0} >> sh);
      b_side.st    <= 30'(a_at >> sh);
      b_side.neg_x <= a_nx;
      b_side.neg_y <= a_ny;
      b_side.neg_t <= a_nt;
      b_side.goal  <= a_goal;
      b_side.angle <= a_ang;
    end
  end

  // stage c: squares
  logic        c_v;
  logic [59:0] c_sqx, c_sqy, c_sqt;
  pre_t        c_side;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx  <= 60'(b_side.sx) * 60'(b_side.sx);
      c_sqy  <= 60'(b_side.sy) * 60'(b_side.sy);
      c_sqt  <= 60'(b_side.st) * 60'(b_side.st);
      c_side <= b_side;
    end
  end

  // stage d: sum of squares feeds the square root chain
  logic sq_v [0:SQRT_STEPS];
  sq_t  sq_d [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= c_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[0].rem  <= 62'(c_sqx) + 62'(c_sqy) + 62'(c_sqt);
      sq_d[0].root <= '0;
      sq_d[0].side <= c_side;
    end
  end

  // square root cells, most significant root bit first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    gtgvc_sqrt_cell #(.BIT(SQRT_STEPS - 1 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .v_in (sq_v[k]),
      .d_in (sq_d[k]),
      .v_out(sq_v[k+1]),
      .d_out(sq_d[k+1])
    );
  end

  // numerators cruise*|axis| + n/2 for the divider
  logic dv_v [0:DIV_STEPS];
  dv_t  dv_d [0:DIV_STEPS];
  pre_t sq_side;
  logic [30:0] n_root;

  assign sq_side = sq_d[SQRT_STEPS].side;
  assign n_root  = sq_d[SQRT_STEPS].root;

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0].n          <= n_root;
      dv_d[0].rem_x      <= 46'(cruise) * 46'(sq_side.sx) + 46'(n_root >> 1);
      dv_d[0].rem_y      <= 46'(cruise) * 46'(sq_side.sy) + 46'(n_root >> 1);
      dv_d[0].rem_t      <= 46'(cruise) * 46'(sq_side.st) + 46'(n_root >> 1);
      dv_d[0].q_x        <= '0;
      dv_d[0].q_y        <= '0;
      dv_d[0].q_t        <= '0;
      dv_d[0].side.neg_x <= sq_side.neg_x;
      dv_d[0].side.neg_y <= sq_side.neg_y;
      dv_d[0].side.neg_t <= sq_side.neg_t;
      dv_d[0].side.goal  <= sq_side.goal;
      dv_d[0].side.zero  <= (n_root == 31'd0);
      dv_d[0].side.angle <= sq_side.angle;
    end
  end

  // divider cells
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    gtgvc_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .v_in (dv_v[k]),
      .d_in (dv_d[k]),
      .v_out(dv_v[k+1]),
      .d_out(dv_d[k+1])
    );
  end

  // fold into the cordic range and scale by 2^14
  logic cd_v [0:NC];
  cd_t  cd_d [0:NC];
  dv_t  dq;
  logic signed [15:0] fvx, fvy;
  logic signed [32:0] fx, fy;
  logic signed [33:0] fa;
  cd_t  fold;

  assign dq  = dv_d[DIV_STEPS];
  assign fvx = dq.side.neg_x ? -16'(dq.q_x) : 16'(dq.q_x);
  assign fvy = dq.side.neg_y ? -16'(dq.q_y) : 16'(dq.q_y);
  assign fx  = 33'(fvx) <<< 14;
  assign fy  = 33'(fvy) <<< 14;
  assign fa  = 34'(dq.side.angle);

  always_comb begin
    fold.x    = fx;
    fold.y    = fy;
    fold.z    = fa;
    fold.vt   = dq.side.neg_t ? -16'(dq.q_t) : 16'(dq.q_t);
    fold.goal = dq.side.goal;
    fold.zero = dq.side.zero;
    if (fa > HALF_Z) begin
      fold.z = fa - PI_Z;
      fold.x = -fx;
      fold.y = -fy;
    end else if (fa < -HALF_Z) begin
      fold.z = fa + PI_Z;
      fold.x = -fx;
      fold.y = -fy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cd_v[0] <= 1'b0;
    else if (en) cd_v[0] <= dv_v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) cd_d[0] <= fold;
  end

  // cordic cells
  for (genvar k = 0; k < NC; k++) begin : g_cordic
    gtgvc_cordic_cell #(.IDX(k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .v_in (cd_v[k]),
      .d_in (cd_d[k]),
      .v_out(cd_v[k+1]),
      .d_out(cd_d[k+1])
    );
  end

  // gain correction products
  logic               m_v, m_goal, m_zero;
  logic signed [49:0] m_px, m_py;
  logic signed [15:0] m_vt;
  cd_t                cq;

  assign cq = cd_d[NC];

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= cd_v[NC];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px   <= 50'(cq.x) * INV_GAIN;
      m_py   <= 50'(cq.y) * INV_GAIN;
      m_vt   <= cq.vt;
      m_goal <= cq.goal;
      m_zero <= cq.zero;
    end
  end

  // rounding, clamping and the goal / zero-norm overrides
  logic               p_v;
  res_t               p_d, p_next;
  logic signed [19:0] rvx, rvy, bvx, bvy, bvt;

  assign rvx = 20'((m_px + RND_HALF) >>> 30);
  assign rvy = 20'((m_py + RND_HALF) >>> 30);
  assign bvx = bound(rvx, max_lin, min_lin);
  assign bvy = bound(rvy, max_lin, min_lin);
  assign bvt = bound(20'(m_vt), max_ang, min_ang);

  always_comb begin
    p_next.vel_x        = bvx[15:0];
    p_next.vel_y        = bvy[15:0];
    p_next.vel_turn     = bvt[15:0];
    p_next.goal_reached = 1'b0;
    if (m_goal || m_zero) begin
      p_next.vel_x    = '0;
      p_next.vel_y    = '0;
      p_next.vel_turn = '0;
    end
    if (m_goal) p_next.goal_reached = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= m_v;
  end

  always_ff @(posedge clk) begin
    if (en) p_d <= p_next;
  end

  // output register and skid register
  logic o_v;
  res_t o_d, s_d;
  logic o_fire;

  assign o_fire = o_v && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else if (s_v) begin
      if (o_fire) s_v <= 1'b0;
    end else if (!o_v || o_fire) begin
      o_v <= p_v;
    end else if (p_v) begin
      s_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v) begin
      if (o_fire) o_d <= s_d;
    end else if (!o_v || o_fire) begin
      o_d <= p_d;
    end else if (p_v) begin
      s_d <= p_d;
    end
  end

  assign out_valid    = o_v;
  assign vel_x        = o_d.vel_x;
  assign vel_y        = o_d.vel_y;
  assign vel_turn     = o_d.vel_turn;
  assign goal_reached = o_d.goal_reached;

endmodule

/* hw/rtl/gtgvc_sqrt_cell.sv */
// one bit of the pipelined integer square root
module gtgvc_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             v_in,
  input  gtgvc_pkg::sq_t   d_in,
  output logic             v_out,
  output gtgvc_pkg::sq_t   d_out
);
  import gtgvc_pkg::*;

  logic [63:0] trial;
  sq_t         nxt;

  // trial subtrahend (2*root + 2^bit) * 2^bit
  assign trial = ({33'd0, d_in.root} << (BIT + 1)) | (64'd1 << (2 * BIT));

  always_comb begin
    nxt = d_in;
    if ({2'b00, d_in.rem} >= trial) begin
      nxt.rem  = d_in.rem - trial[61:0];
      nxt.root = d_in.root | (31'd1 << BIT);
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

/* hw/rtl/gtgvc_div_cell.sv */
// one quotient bit of the three-lane restoring divider
module gtgvc_div_cell #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             v_in,
  input  gtgvc_pkg::dv_t   d_in,
  output logic             v_out,
  output gtgvc_pkg::dv_t   d_out
);
  import gtgvc_pkg::*;

  logic [46:0] dsh;
  logic [46:0] rx;
  logic [46:0] ry;
  logic [46:0] rt;
  dv_t         nxt;

  // compare and subtract, quotient bit on top
  function automatic logic [46:0] dstep(logic [45:0] rem, logic [46:0] d);
    if ({1'b0, rem} >= d) return {1'b1, rem - d[45:0]};
    return {1'b0, rem};
  endfunction

  assign dsh = 47'(d_in.n) << BIT;
  assign rx  = dstep(d_in.rem_x, dsh);
  assign ry  = dstep(d_in.rem_y, dsh);
  assign rt  = dstep(d_in.rem_t, dsh);

  always_comb begin
    nxt          = d_in;
    nxt.rem_x    = rx[45:0];
    nxt.rem_y    = ry[45:0];
    nxt.rem_t    = rt[45:0];
    nxt.q_x[BIT] = rx[46];
    nxt.q_y[BIT] = ry[46];
    nxt.q_t[BIT] = rt[46];
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

/* hw/rtl/gtgvc_cordic_cell.sv */
// one rotation step of the cordic chain
module gtgvc_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             v_in,
  input  gtgvc_pkg::cd_t   d_in,
  output logic             v_out,
  output gtgvc_pkg::cd_t   d_out
);
  import gtgvc_pkg::*;

  localparam logic signed [33:0] AT = 34'(ATAN_Q30[IDX]);

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  cd_t                nxt;

  assign x  = d_in.x;
  assign y  = d_in.y;
  assign xs = x >>> IDX;
  assign ys = y >>> IDX;

  // rotate toward zero residual angle
  always_comb begin
    nxt = d_in;
    if (d_in.z >= 0) begin
      nxt.x = x - ys;
      nxt.y = y + xs;
      nxt.z = d_in.z - AT;
    end else begin
      nxt.x = x + ys;
      nxt.y = y - xs;
      nxt.z = d_in.z + AT;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

/* hw/rtl/gtgvc_checker.sv */
// port-level checks of the go-to-goal velocity command unit, bound to the top level
module gtgvc_props (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] vel_x,
  input logic signed [15:0] vel_y,
  input logic signed [15:0] vel_turn,
  input logic               goal_reached
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vel_x) && $stable(vel_y)
      && $stable(vel_turn) && $stable(goal_reached))
    else $error("stalled result changed");

  // goal reached means a zero command
  a_goal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && goal_reached |-> vel_x == 16'sd0 && vel_y == 16'sd0 && vel_turn == 16'sd0)
    else $error("goal reached with nonzero velocity");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // input back-pressure only follows a stalled output transfer
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind go_to_goal_velocity_command_unit gtgvc_props u_gtgvc_props (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .vel_x       (vel_x),
  .vel_y       (vel_y),
  .vel_turn    (vel_turn),
  .goal_reached(goal_reached)
);
